// ===== rtl/core/smf_track_event_parser_macros.svh =====
// Assertion macros used by the track event parser top level
`ifndef SMF_TRACK_EVENT_PARSER_MACROS_SVH
`define SMF_TRACK_EVENT_PARSER_MACROS_SVH

// same-cycle implication, idle during reset
`define SMF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, idle during reset
`define SMF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/smf_pkg.sv =====
// Types and constants of the track event parser
`timescale 1ns / 1ps

package smf_pkg;

    localparam int OPEN_DEPTH = 32;

    localparam logic [7:0] BYTE_META      = 8'hFF;
    localparam logic [7:0] BYTE_SYSEX     = 8'hF0;
    localparam logic [7:0] BYTE_ESCAPE    = 8'hF7;
    localparam logic [7:0] BYTE_SYSTEM    = 8'hF0;
    localparam logic [7:0] META_END_TRACK = 8'h2F;
    localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON   = 4'h9;
    localparam logic [3:0] KIND_PROGRAM   = 4'hC;
    localparam logic [3:0] KIND_PRESSURE  = 4'hD;
    localparam logic [15:0] NOTE_LIMIT_RESET = 16'd4096;
    localparam logic [2:0] VLQ_MAX_BYTES  = 3'd4;

    typedef struct packed {
        logic        valid;
        logic [3:0]  channel;
        logic [6:0]  pitch;
        logic [6:0]  velocity;
        logic [31:0] start;
    } entry_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_MATCH,
        OP_CLOSE,
        OP_POP
    } list_op_t;

    typedef struct packed {
        list_op_t   op;
        logic [3:0] channel;
        logic [6:0] pitch;
        entry_t     fresh;
    } list_cmd_t;

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_META_TYPE,
        PH_META_LEN,
        PH_SYSEX_LEN,
        PH_SKIP,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CLOSE,
        S_FOLD,
        S_FLUSH,
        S_SUMMARY
    } state_t;

endpackage

// ===== rtl/core/smf_cell.sv =====
// One open-note cell of the ordered list
`timescale 1ns / 1ps

module smf_cell import smf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  list_cmd_t cmd,
    input  logic      prev_valid,
    input  entry_t    right_entry,
    input  logic      hit_in,
    input  entry_t    sel_in,
    output entry_t    entry,
    output logic      hit_out,
    output entry_t    sel_out
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   match_reg;
    logic   match_next;

    assign entry   = entry_reg;
    assign hit_out = hit_in | match_reg;
    assign sel_out = (!hit_in && match_reg) ? entry_reg : sel_in;

    always_comb begin
        entry_next = entry_reg;
        match_next = match_reg;
        unique case (cmd.op)
            OP_INSERT: begin
                if (!entry_reg.valid && prev_valid) begin
                    entry_next = cmd.fresh;
                end
            end
            OP_MATCH: begin
                match_next = entry_reg.valid && (entry_reg.channel == cmd.channel)
                             && (entry_reg.pitch == cmd.pitch);
            end
            OP_CLOSE: begin
                if (hit_out) begin
                    entry_next = right_entry;
                end
            end
            OP_POP:  entry_next = right_entry;
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
            match_reg       <= 1'b0;
        end else begin
            entry_reg.valid <= entry_next.valid;
            match_reg       <= match_next;
        end
        entry_reg.channel  <= entry_next.channel;
        entry_reg.pitch    <= entry_next.pitch;
        entry_reg.velocity <= entry_next.velocity;
        entry_reg.start    <= entry_next.start;
    end

endmodule

// ===== rtl/core/smf_open_list.sv =====
// Row of open-note cells with match and shift chains
`timescale 1ns / 1ps

module smf_open_list import smf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  list_cmd_t cmd,
    output entry_t    head,
    output logic      full,
    output logic      found,
    output entry_t    sel
);

    entry_t ent [OPEN_DEPTH];
    entry_t sels[OPEN_DEPTH];
    logic   hits[OPEN_DEPTH];

    genvar i;
    generate
        for (i = 0; i < OPEN_DEPTH; i++) begin : g_cell
            logic   pv;
            entry_t re;
            logic   hi;
            entry_t si;
            if (i == 0) begin : g_first
                assign pv = 1'b1;
                assign hi = 1'b0;
                assign si = '0;
            end else begin : g_rest
                assign pv = ent[i-1].valid;
                assign hi = hits[i-1];
                assign si = sels[i-1];
            end
            if (i == OPEN_DEPTH - 1) begin : g_last
                assign re = '0;
            end else begin : g_inner
                assign re = ent[i+1];
            end
            smf_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd),
                .prev_valid  (pv),
                .right_entry (re),
                .hit_in      (hi),
                .sel_in      (si),
                .entry       (ent[i]),
                .hit_out     (hits[i]),
                .sel_out     (sels[i])
            );
        end
    endgenerate

    assign head  = ent[0];
    assign full  = ent[OPEN_DEPTH-1].valid;
    assign found = hits[OPEN_DEPTH-1];
    assign sel   = sels[OPEN_DEPTH-1];

endmodule

// ===== rtl/core/smf_track_event_parser.sv =====
// Top level of the track event parser: byte decoder, sequencer and output register
// A byte is decoded in S_EXEC; a note-off or zero-velocity note-on also passes S_CLOSE.
// s_tready is high only in S_IDLE, so no new byte is taken until the last one is through.
// A flush passes S_FOLD, pops each held note in S_FLUSH, then emits the summary.
// Output stalls hold the sequencer until the output register frees.
// Reset (aresetn low, synchronous) clears control state and the list; note_limit to 4096.
`timescale 1ns / 1ps
`include "smf_track_event_parser_macros.svh"

module smf_track_event_parser import smf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // track_byte[7:0]
    input  logic        s_tuser,   // req_type
    input  logic        s_tlast,   // track_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // pitch[6:0], velocity[13:7], start_tick[45:14],
                                   // end_tick[77:46], too_many_notes[78], open_overflow[79]
    output logic        m_tuser,   // kind
    output logic        m_tlast    // last
);

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  rs_reg, rs_next, es_reg, es_next, mk_reg, mk_next, fd_reg, fd_next;
    logic [31:0] tick_reg, tick_next, acc_reg, acc_next, skip_reg, skip_next;
    logic [31:0] content_reg, content_next, close_tick_reg;
    logic [2:0]  cnt_reg, cnt_next;
    logic [15:0] notes_reg, notes_next, limit_reg;
    logic [1:0]  flags_reg, flags_next;
    logic [7:0]  byte_reg;
    logic        tend_reg;

    logic        m_valid_reg, m_user_reg, m_last_reg;
    logic [79:0] m_data_reg;

    list_cmd_t   cmd;
    entry_t      head, sel;
    logic        full, found;

    logic        do_insert, do_match, out_free, out_load, out_kind, out_last;
    entry_t      out_ent;
    logic [31:0] out_end;

    logic [31:0] acc_v, tick_mid;
    logic [2:0]  cnt_v;
    logic [32:0] sum_v;

    smf_open_list u_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .head    (head),
        .full    (full),
        .found   (found),
        .sel     (sel)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign acc_v    = {acc_reg[24:0], byte_reg[6:0]};
    assign cnt_v    = cnt_reg + 3'd1;
    assign sum_v    = {1'b0, tick_reg} + {1'b0, acc_v};

    always_comb begin
        phase_next   = phase_reg;
        rs_next      = rs_reg;
        es_next      = es_reg;
        mk_next      = mk_reg;
        fd_next      = fd_reg;
        tick_next    = tick_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        skip_next    = skip_reg;
        content_next = content_reg;
        notes_next   = notes_reg;
        flags_next   = flags_reg;
        do_insert    = 1'b0;
        do_match     = 1'b0;
        tick_mid     = tick_reg;
        if (state_reg == S_EXEC) begin
            unique case (phase_reg)
                PH_DELTA: begin
                    if (!byte_reg[7]) begin
                        tick_mid   = sum_v[32] ? '1 : sum_v[31:0];
                        acc_next   = '0;
                        cnt_next   = '0;
                        phase_next = PH_STATUS;
                    end else begin
                        acc_next = acc_v;
                        cnt_next = cnt_v;
                        if (cnt_v >= VLQ_MAX_BYTES) begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_STATUS: begin
                    if (!byte_reg[7]) begin
                        if (rs_reg == '0) begin
                            phase_next = PH_DONE;
                        end else begin
                            es_next = rs_reg;
                            fd_next = byte_reg;
                            phase_next = (rs_reg[7:4] == KIND_PROGRAM ||
                                          rs_reg[7:4] == KIND_PRESSURE) ? PH_DELTA : PH_DATA2;
                        end
                    end else begin
                        rs_next = (byte_reg < BYTE_SYSTEM) ? byte_reg : '0;
                        es_next = byte_reg;
                        if (byte_reg == BYTE_META) begin
                            phase_next = PH_META_TYPE;
                        end else if (byte_reg == BYTE_SYSEX || byte_reg == BYTE_ESCAPE) begin
                            phase_next = PH_SYSEX_LEN;
                        end else begin
                            phase_next = PH_DATA1;
                        end
                    end
                end
                PH_DATA1: begin
                    fd_next = byte_reg;
                    phase_next = (es_reg[7:4] == KIND_PROGRAM ||
                                  es_reg[7:4] == KIND_PRESSURE) ? PH_DELTA : PH_DATA2;
                end
                PH_DATA2: begin
                    phase_next = PH_DELTA;
                    if (es_reg[7:4] == KIND_NOTE_ON && byte_reg != '0) begin
                        if (notes_reg >= limit_reg) begin
                            flags_next[0] = 1'b1;
                        end else if (full) begin
                            flags_next[1] = 1'b1;
                        end else begin
                            do_insert  = 1'b1;
                            notes_next = notes_reg + 16'd1;
                        end
                    end else if (es_reg[7:4] == KIND_NOTE_ON || es_reg[7:4] == KIND_NOTE_OFF) begin
                        do_match = 1'b1;
                    end
                end
                PH_META_TYPE: begin
                    mk_next    = byte_reg;
                    phase_next = PH_META_LEN;
                end
                PH_META_LEN, PH_SYSEX_LEN: begin
                    if (!byte_reg[7]) begin
                        skip_next = acc_v;
                        acc_next  = '0;
                        cnt_next  = '0;
                        if (phase_reg == PH_META_LEN && mk_reg == META_END_TRACK) begin
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = (acc_v == '0) ? PH_DELTA : PH_SKIP;
                        end
                    end else begin
                        acc_next = acc_v;
                        cnt_next = cnt_v;
                        if (cnt_v >= VLQ_MAX_BYTES) begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                PH_SKIP: begin
                    if (skip_reg != '0) begin
                        skip_next = skip_reg - 32'd1;
                    end
                    if (skip_reg <= 32'd1) begin
                        phase_next = PH_DELTA;
                    end
                end
                PH_DONE: phase_next = PH_DONE;
                default: phase_next = PH_DONE;
            endcase
            tick_next = tick_mid;
        end
        if ((state_reg == S_EXEC && tend_reg) || state_reg == S_FOLD) begin
            if (tick_mid > content_reg) begin
                content_next = tick_mid;
            end
            phase_next = PH_DELTA;
            rs_next    = '0;
            es_next    = '0;
            mk_next    = '0;
            fd_next    = '0;
            tick_next  = '0;
            acc_next   = '0;
            cnt_next   = '0;
            skip_next  = '0;
        end
        if (state_reg == S_SUMMARY && out_free) begin
            content_next = '0;
            notes_next   = '0;
            flags_next   = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = s_tuser ? S_FOLD : S_EXEC;
                end
            end
            S_EXEC:  state_next = do_match ? S_CLOSE : S_IDLE;
            S_CLOSE: begin
                if (!found || close_tick_reg <= sel.start || out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_FOLD:  state_next = S_FLUSH;
            S_FLUSH: begin
                if (!head.valid) begin
                    state_next = S_SUMMARY;
                end
            end
            S_SUMMARY: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.op       = OP_NONE;
        cmd.channel  = es_reg[3:0];
        cmd.pitch    = fd_reg[6:0];
        cmd.fresh    = '{valid: 1'b1, channel: es_reg[3:0], pitch: fd_reg[6:0],
                         velocity: byte_reg[6:0], start: tick_reg};
        out_load     = 1'b0;
        out_kind     = 1'b0;
        out_last     = 1'b0;
        out_ent      = sel;
        out_end      = close_tick_reg;
        unique case (state_reg)
            S_EXEC: begin
                if (do_insert) begin
                    cmd.op = OP_INSERT;
                end else if (do_match) begin
                    cmd.op = OP_MATCH;
                end
            end
            S_CLOSE: begin
                if (found) begin
                    if (close_tick_reg > sel.start) begin
                        if (out_free) begin
                            out_load = 1'b1;
                            out_last = 1'b1;
                            cmd.op   = OP_CLOSE;
                        end
                    end else begin
                        cmd.op = OP_CLOSE;
                    end
                end
            end
            S_FLUSH: begin
                out_ent = head;
                out_end = content_reg;
                if (head.valid) begin
                    if (content_reg > head.start) begin
                        if (out_free) begin
                            out_load = 1'b1;
                            cmd.op   = OP_POP;
                        end
                    end else begin
                        cmd.op = OP_POP;
                    end
                end
            end
            S_SUMMARY: begin
                out_ent  = '0;
                out_end  = content_reg;
                out_kind = 1'b1;
                out_last = 1'b1;
                out_load = out_free;
            end
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_DELTA;
            rs_reg      <= '0;
            es_reg      <= '0;
            mk_reg      <= '0;
            fd_reg      <= '0;
            tick_reg    <= '0;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            skip_reg    <= '0;
            content_reg <= '0;
            notes_reg   <= '0;
            flags_reg   <= '0;
            limit_reg   <= NOTE_LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            rs_reg      <= rs_next;
            es_reg      <= es_next;
            mk_reg      <= mk_next;
            fd_reg      <= fd_next;
            tick_reg    <= tick_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            skip_reg    <= skip_next;
            content_reg <= content_next;
            notes_reg   <= notes_next;
            flags_reg   <= flags_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
            tend_reg <= s_tlast;
        end
        if (state_reg == S_EXEC) begin
            close_tick_reg <= tick_reg;
        end
        if (out_load) begin
            m_data_reg <= {flags_reg[1], flags_reg[0], out_end, out_ent.start,
                           out_ent.velocity, out_ent.pitch};
            m_user_reg <= out_kind;
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    `SMF_ASSERT_IMP(a_summary_last, m_valid_reg && m_user_reg, m_last_reg)
    `SMF_ASSERT_IMP(a_summary_empty, state_reg == S_SUMMARY, !head.valid)
    `SMF_ASSERT_NXT(a_accept_starts, s_tvalid && s_tready,
                    state_reg == S_EXEC || state_reg == S_FOLD)

endmodule

// ===== tb/smf_note_checker.sv =====
// Checker for the track event parser: predicts completed notes and summaries and compares them
`timescale 1ns / 1ps

module smf_note_checker import smf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          notes_pending
);

    localparam int VLQ_WAIT = 0;
    localparam int VLQ_DONE = 1;
    localparam int VLQ_BAD  = 2;

    typedef struct packed {
        logic        kind;
        logic [6:0]  pitch;
        logic [6:0]  velocity;
        logic [31:0] start_tick;
        logic [31:0] end_tick;
        logic        too_many;
        logic        overflow;
        logic        last;
    } note_rec_t;

    note_rec_t   note_q[$];
    phase_t      phase;
    logic [7:0]  run_status, ev_status, meta_code, first_byte;
    logic [31:0] tick, vlq_acc, skip_cnt, content_end;
    logic [2:0]  vlq_cnt;
    logic [15:0] note_total, limit;
    logic [1:0]  flags;
    entry_t      cells [OPEN_DEPTH];

    task automatic push_note(logic k, logic [6:0] p, logic [6:0] v,
                             logic [31:0] st, logic [31:0] en);
        note_rec_t r;
        r.kind = k; r.pitch = p; r.velocity = v; r.start_tick = st; r.end_tick = en;
        r.too_many = flags[0]; r.overflow = flags[1]; r.last = 1'b0;
        note_q = {note_q, r};
    endtask

    task automatic clear_track();
        phase = PH_DELTA; run_status = '0; tick = '0; vlq_acc = '0; vlq_cnt = '0;
        ev_status = '0; meta_code = '0; skip_cnt = '0; first_byte = '0;
    endtask

    task automatic clear_file();
        clear_track();
        content_end = '0; note_total = '0; flags = '0;
        for (int i = 0; i < OPEN_DEPTH; i++) cells[i] = '0;
    endtask

    task automatic close_track();
        if (tick > content_end) content_end = tick;
        clear_track();
    endtask

    function automatic int vlq_step(logic [7:0] b);
        vlq_acc = (vlq_acc << 7) | {25'd0, b[6:0]};
        vlq_cnt = vlq_cnt + 3'd1;
        if (!b[7]) return VLQ_DONE;
        return (vlq_cnt >= VLQ_MAX_BYTES) ? VLQ_BAD : VLQ_WAIT;
    endfunction

    task automatic take_first(logic [7:0] b);
        first_byte = b;
        if (ev_status[7:4] == KIND_PROGRAM || ev_status[7:4] == KIND_PRESSURE)
            phase = PH_DELTA;
        else
            phase = PH_DATA2;
    endtask

    task automatic note_event(logic [7:0] second);
        logic [3:0] ch;
        logic [6:0] p;
        bit         placed;
        entry_t     hit;
        ch = ev_status[3:0];
        p = first_byte[6:0];
        placed = 0;
        if (ev_status[7:4] == KIND_NOTE_ON && second != 0) begin
            if (note_total >= limit) begin
                flags[0] = 1'b1;
            end else begin
                for (int i = 0; i < OPEN_DEPTH; i++) begin
                    if (!placed && !cells[i].valid) begin
                        cells[i] = '{1'b1, ch, p, second[6:0], tick};
                        note_total = note_total + 16'd1;
                        placed = 1;
                    end
                end
                if (!placed) flags[1] = 1'b1;
            end
        end else if (ev_status[7:4] == KIND_NOTE_OFF || ev_status[7:4] == KIND_NOTE_ON) begin
            for (int i = 0; i < OPEN_DEPTH; i++) begin
                if (!placed && cells[i].valid && cells[i].channel == ch && cells[i].pitch == p)
                begin
                    hit = cells[i];
                    for (int j = i; j < OPEN_DEPTH - 1; j++) cells[j] = cells[j + 1];
                    cells[OPEN_DEPTH - 1] = '0;
                    if (tick > hit.start) push_note(1'b0, hit.pitch, hit.velocity, hit.start, tick);
                    placed = 1;
                end
            end
        end
    endtask

    task automatic decode_byte(logic [7:0] b);
        int v;
        logic [32:0] sum;
        case (phase)
            PH_DELTA: begin
                v = vlq_step(b);
                if (v == VLQ_DONE) begin
                    sum = {1'b0, tick} + {1'b0, vlq_acc};
                    tick = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    vlq_acc = '0; vlq_cnt = '0;
                    phase = PH_STATUS;
                end else if (v == VLQ_BAD) begin
                    phase = PH_DONE;
                end
            end
            PH_STATUS: begin
                if (!b[7]) begin
                    if (run_status == 0) begin
                        phase = PH_DONE;
                    end else begin
                        ev_status = run_status;
                        take_first(b);
                    end
                end else begin
                    run_status = (b < BYTE_SYSTEM) ? b : 8'h00;
                    ev_status = b;
                    if (b == BYTE_META) phase = PH_META_TYPE;
                    else if (b == BYTE_SYSEX || b == BYTE_ESCAPE) phase = PH_SYSEX_LEN;
                    else phase = PH_DATA1;
                end
            end
            PH_DATA1: take_first(b);
            PH_DATA2: begin
                phase = PH_DELTA;
                note_event(b);
            end
            PH_META_TYPE: begin
                meta_code = b;
                phase = PH_META_LEN;
            end
            PH_META_LEN, PH_SYSEX_LEN: begin
                v = vlq_step(b);
                if (v == VLQ_BAD) begin
                    phase = PH_DONE;
                end else if (v == VLQ_DONE) begin
                    skip_cnt = vlq_acc;
                    vlq_acc = '0; vlq_cnt = '0;
                    if (phase == PH_META_LEN && meta_code == META_END_TRACK) phase = PH_DONE;
                    else phase = (skip_cnt == 0) ? PH_DELTA : PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (skip_cnt > 0) skip_cnt = skip_cnt - 32'd1;
                if (skip_cnt == 0) phase = PH_DELTA;
            end
            default: ;
        endcase
    endtask

    task automatic predict(logic flush, logic [7:0] b, logic track_end);
        int n0;
        n0 = note_q.size();
        if (flush) begin
            close_track();
            for (int i = 0; i < OPEN_DEPTH; i++)
                if (cells[i].valid && content_end > cells[i].start)
                    push_note(1'b0, cells[i].pitch, cells[i].velocity, cells[i].start,
                              content_end);
            push_note(1'b1, '0, '0, '0, content_end);
            clear_file();
        end else begin
            decode_byte(b);
            if (track_end) close_track();
        end
        if (note_q.size() > n0) note_q[$].last = 1'b1;
    endtask

    task automatic compare(note_rec_t got);
        note_rec_t want;
        if (note_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected result %p", got);
            return;
        end
        want = note_q.pop_front();
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
    endtask

    initial begin
        fail_count = 0;
        notes_pending = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_file();
            limit = NOTE_LIMIT_RESET;
            note_q.delete();
        end else begin
            if (cfg_wr_en) limit = cfg_wr_data;
            if (s_tvalid && s_tready) predict(s_tuser, s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                compare('{m_tuser, m_tdata[6:0], m_tdata[13:7], m_tdata[45:14],
                          m_tdata[77:46], m_tdata[78], m_tdata[79], m_tlast});
        end
        notes_pending = note_q.size();
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the track event parser: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb import smf_pkg::*; ();

    typedef struct packed {
        logic       flush;
        logic [7:0] b;
        logic       e;
    } smf_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          fail_count, notes_pending;
    bit          calm = 0;
    smf_req_t    byte_q[$];

    smf_track_event_parser uut (.*);

    smf_note_checker checker_i (.*);

    always #10 aclk = ~aclk;

    always @(posedge aclk) m_tready <= calm || ($urandom_range(99) >= 24);

    initial begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void put(logic [7:0] b);
        smf_req_t it;
        it = '{1'b0, b, 1'b0};
        byte_q = {byte_q, it};
    endfunction

    function automatic void put_vlq(logic [31:0] v);
        int n;
        n = 1;
        while (n < 4 && (v >> (7 * n)) != 0) n++;
        for (int i = n - 1; i >= 0; i--)
            put(8'((v >> (7 * i)) & 32'h7F) | ((i > 0) ? 8'h80 : 8'h00));
    endfunction

    function automatic void mark_end();
        if (byte_q.size() == 0 || byte_q[$].flush) put(8'h00);
        byte_q[$].e = 1'b1;
    endfunction

    function automatic void put_flush();
        smf_req_t it;
        it = '{1'b1, 8'($urandom), 1'($urandom)};
        byte_q = {byte_q, it};
    endfunction

    function automatic logic [7:0] pick_pitch();
        if ($urandom_range(9) == 0) return 8'($urandom);
        return 8'($urandom_range(60, 63));
    endfunction

    function automatic void rand_track(int events);
        logic [7:0] st;
        int r;
        st = '0;
        for (int k = 0; k < events; k++) begin
            r = $urandom_range(99);
            if (r < 80) put_vlq($urandom_range(3));
            else if (r < 93) put_vlq($urandom_range(20000));
            else if (r < 98) put_vlq($urandom_range(32'h0FFF_FFFF));
            else begin
                put(8'h81); put(8'h81); put(8'h81); put(8'h81); put(8'h01);
            end
            r = $urandom_range(99);
            if (r < 60) begin
                logic [7:0] ns;
                if (r < 35) ns = {KIND_NOTE_ON, 4'($urandom_range(1))};
                else ns = {($urandom_range(1) ? KIND_NOTE_OFF : KIND_NOTE_ON),
                           4'($urandom_range(1))};
                if ($urandom_range(9) == 0) ns[3:0] = 4'($urandom);
                if (!(st == ns && $urandom_range(1))) put(ns);
                st = ns;
                put(pick_pitch());
                if (r < 35) put(8'($urandom_range(1, 127)));
                else if (ns[7:4] == KIND_NOTE_ON) put(8'h00);
                else put(8'($urandom));
            end else if (r < 68) begin
                st = {($urandom_range(1) ? KIND_PROGRAM : KIND_PRESSURE), 4'($urandom)};
                put(st); put(8'($urandom_range(127)));
            end else if (r < 74) begin
                st = 8'hB0 | 8'($urandom_range(15));
                put(st); put(8'($urandom_range(127))); put(8'($urandom_range(127)));
            end else if (r < 82) begin
                int len;
                len = $urandom_range(3);
                put(BYTE_META);
                put(8'($urandom_range(1, 127)));
                put_vlq(len);
                for (int i = 0; i < len; i++) put(8'($urandom));
                st = '0;
            end else if (r < 87) begin
                int len;
                len = $urandom_range(3);
                put($urandom_range(1) ? BYTE_SYSEX : BYTE_ESCAPE);
                put_vlq(len);
                for (int i = 0; i < len; i++) put(8'($urandom));
                st = '0;
            end else if (r < 91) begin
                logic [7:0] sys;
                sys = 8'($urandom_range(8'hF1, 8'hFE));
                if (sys == BYTE_ESCAPE) sys = 8'hF1;
                put(sys); put(8'($urandom)); put(8'($urandom));
                st = '0;
            end else begin
                put(8'($urandom));
            end
        end
        r = $urandom_range(99);
        if (r < 60) begin
            put(8'h00); put(BYTE_META); put(META_END_TRACK); put(8'h00);
            for (int i = $urandom_range(2); i > 0; i--) put(8'($urandom));
        end else if (r < 80) begin
            put(8'h00); put({KIND_NOTE_ON, 4'h0});
        end
        mark_end();
    endfunction

    function automatic void rand_file(int tracks);
        for (int t = 0; t < tracks; t++) rand_track($urandom_range(3, 6));
        if ($urandom_range(3) == 0) rand_track(2);
        if ($urandom_range(3) == 0) begin
            put(8'h00); put({KIND_NOTE_ON, 4'h1}); put(8'd62); put(8'd50);
        end
        put_flush();
    endfunction

    task automatic send(smf_req_t it);
        if (!calm)
            while ($urandom_range(99) < 24) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        s_tvalid <= 1'b1;
        s_tuser <= it.flush;
        s_tdata <= it.b;
        s_tlast <= it.e;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic run_bytes();
        while (byte_q.size() > 0) send(byte_q.pop_front());
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (notes_pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_limit(logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // note closed by running-status velocity zero, then a zero-length note
        put(8'h00); put(8'h90); put(8'h3C); put(8'h7F);
        put(8'h05); put(8'h3C); put(8'h00);
        put(8'h00); put(8'h90); put(8'h3D); put(8'h40);
        put(8'h00); put(8'h80); put(8'h3D); put(8'h00);
        // two-byte delta, program change, out-of-range data bytes, other system
        put(8'h81); put(8'h00); put(8'hC5); put(8'h05);
        put(8'h00); put(8'h92); put(8'hBC); put(8'h81);
        put(8'h00); put(8'hF2); put(8'h01); put(8'h02);
        mark_end();
        put(8'h00); put(8'h40); mark_end();
        put(8'h81); put(8'h81); put(8'h81); put(8'h81); put(8'h01); mark_end();
        put_flush();
        run_bytes();

        // overflow the open list
        write_limit(16'hFFFF);
        put(8'h00); put({KIND_NOTE_ON, 4'h3}); put(8'd0); put(8'd20);
        for (int i = 1; i <= OPEN_DEPTH; i++) begin
            put(8'h01); put(8'(i)); put(8'd20);
        end
        mark_end();
        put_flush();
        run_bytes();

        write_limit(16'd1);
        rand_file(1);
        run_bytes();

        write_limit(16'd3);
        rand_file(1);
        run_bytes();

        write_limit(NOTE_LIMIT_RESET);
        calm = 1;
        // saturate the track tick
        put_vlq(32'h0FFF_FFFF); put({KIND_PROGRAM, 4'h0}); put(8'h00);
        for (int i = 1; i < 17; i++) begin
            put_vlq(32'h0FFF_FFFF); put(8'h00);
        end
        put(8'h00); put(8'h90); put(8'h40); put(8'h40);
        mark_end();
        put_flush();
        run_bytes();
        calm = 0;

        repeat (50) @(posedge aclk);
        if (fail_count == 0 && notes_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/smf_pkg.sv
rtl/core/smf_cell.sv
rtl/core/smf_open_list.sv
rtl/core/smf_track_event_parser.sv
tb/smf_note_checker.sv
tb/tb.sv
